[src/coospmv_pkg.sv]
package coospmv_pkg;

   // Field widths of the request and response words
   localparam int OP_W      = 3;
   localparam int IDX_W     = 10;
   localparam int DATA_W    = 32;
   localparam int VLEN_W    = 11;
   localparam int CSR_IDX_W = 2;

   // Q16.16 arithmetic
   localparam int FRAC_BITS = 16;
   localparam int LIMB_W    = 32;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD_X  = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD_Y  = 3'd1;
   localparam logic [OP_W-1:0] OP_MARK    = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_TRIPLET = 3'd4;
   localparam logic [OP_W-1:0] OP_READ    = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH    = 2'd3;

   // Register reset values
   localparam logic [DATA_W-1:0] GAIN_ONE   = 32'h0001_0000;
   localparam logic [VLEN_W-1:0] VLEN_RESET = 11'd1024;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic [IDX_W-1:0]         entry_index;
      logic [IDX_W-1:0]         row_number;
      logic [IDX_W-1:0]         column_number;
      logic signed [DATA_W-1:0] data_value;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [IDX_W-1:0]         result_index;
      logic                     read_status;
   } rsp_word_type;

   // Status of the shared multiplier
   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

[src/coo_sparse_matvec_masked_unit.sv]
// Sparse matrix-vector multiply-accumulate, y = beta*y + alpha*A*x (or A transposed), with
// A streamed in as (row, column, value) triplets and all values Q16.16 with saturation.
// One request word is taken at a time; req_ready is low while a word is worked on. Load x,
// mark fixed, unused codes and triplets with an index out of range (which are dropped)
// use no multiplier; load y takes one pass through the single shared multiplier and a
// triplet two, 32x32 when VALUE_WIDTH is at most 32 and in 32-bit limbs beyond it; a
// triplet to a fixed destination leaves after the first pass. Clear fixed marks sweeps
// the fixed-mark memory one entry a cycle; the same sweep runs after reset, and
// req_ready rises when it ends. Register writes are taken in any cycle.
module coo_sparse_matvec_masked_unit
   import coospmv_pkg::*;
#(
   parameter int VECTOR_DEPTH = 1024,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_word_type         req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_word_type         rsp_word,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);

   localparam int ADDR_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
   localparam int X_W    = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
   localparam int OPA_W  = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

   localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_DECODE   = 3'd2;
   localparam logic [2:0] S_LOADY    = 3'd3;
   localparam logic [2:0] S_TRI_MUL1 = 3'd4;
   localparam logic [2:0] S_TRI_MUL2 = 3'd5;
   localparam logic [2:0] S_RESP     = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [ADDR_W-1:0]       clr_cnt_ff, clr_cnt_in;
   req_word_type            req_ff, req_in;
   rsp_word_type            rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_load;

   logic [DATA_W-1:0]       alpha_ff, beta_ff;
   logic                    transpose_ff;
   logic [VLEN_W-1:0]       vlen_ff;

   logic [IDX_W-1:0]        dst_idx, src_idx;
   logic                    idx_ok, dst_ok, src_ok;

   logic                    x_we, x_re;
   logic [X_W-1:0]          x_wdata, x_rd;
   logic                    y_we, y_re;
   logic [ADDR_W-1:0]       y_waddr, y_raddr;
   logic [VALUE_WIDTH-1:0]  y_wdata, y_rd;
   logic [DATA_W-1:0]       y_rd32;
   logic                    mask_we, mask_re;
   logic [ADDR_W-1:0]       mask_waddr;
   logic [0:0]              mask_wbit, mask_rd;

   logic                    mul_start;
   logic signed [OPA_W-1:0] mul_a;
   logic signed [DATA_W-1:0] mul_b;
   logic signed [VALUE_WIDTH-1:0] mul_result;
   mul_stat_type            mul_stat;

   function automatic logic in_span(input logic [IDX_W-1:0] i, input logic [VLEN_W-1:0] len);
      return (VLEN_W'(i) < len) && (int'(i) < VECTOR_DEPTH);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] sat_add(input logic [VALUE_WIDTH-1:0] a,
                                                      input logic [VALUE_WIDTH-1:0] b);
      logic [VALUE_WIDTH:0] s;
      s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
         return s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
      end
      return s[VALUE_WIDTH-1:0];
   endfunction

   assign dst_idx = transpose_ff ? req_ff.column_number : req_ff.row_number;
   assign src_idx = transpose_ff ? req_ff.row_number : req_ff.column_number;
   assign idx_ok  = in_span(req_ff.entry_index, vlen_ff);
   assign dst_ok  = in_span(dst_idx, vlen_ff);
   assign src_ok  = in_span(src_idx, vlen_ff);

   // Saturate an x word into the stored width
   if (VALUE_WIDTH < DATA_W) begin : g_x_narrow
      logic x_fits;
      assign x_fits  = (req_ff.data_value[DATA_W-1:VALUE_WIDTH-1] ==
                        {(DATA_W-VALUE_WIDTH+1){req_ff.data_value[DATA_W-1]}});
      assign x_wdata = x_fits ? req_ff.data_value[X_W-1:0] :
                       {req_ff.data_value[DATA_W-1], {(X_W-1){~req_ff.data_value[DATA_W-1]}}};
   end else begin : g_x_full
      assign x_wdata = req_ff.data_value;
   end

   // Bring a y entry to the 32-bit response word
   if (VALUE_WIDTH <= DATA_W) begin : g_rd_extend
      assign y_rd32 = DATA_W'($signed(y_rd));
   end else begin : g_rd_clamp
      logic y_fits;
      assign y_fits = (y_rd[VALUE_WIDTH-1:DATA_W-1] ==
                       {(VALUE_WIDTH-DATA_W+1){y_rd[VALUE_WIDTH-1]}});
      assign y_rd32 = y_fits ? y_rd[DATA_W-1:0] :
                      {y_rd[VALUE_WIDTH-1], {(DATA_W-1){~y_rd[VALUE_WIDTH-1]}}};
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      req_in     = req_ff;
      rsp_load   = 1'b0;
      x_we       = 1'b0;
      x_re       = 1'b0;
      y_we       = 1'b0;
      y_re       = 1'b0;
      mask_we    = 1'b0;
      mask_re    = 1'b0;
      mask_wbit  = 1'b0;
      mask_waddr = ADDR_W'(req_ff.entry_index);
      y_waddr    = ADDR_W'(req_ff.entry_index);
      y_wdata    = mul_result;
      y_raddr    = ADDR_W'(req_ff.entry_index);
      mul_start  = 1'b0;
      mul_a      = OPA_W'($signed(req_ff.data_value));
      mul_b      = (req_ff.operation == OP_LOAD_Y) ? beta_ff : alpha_ff;
      unique case (state_ff)
         S_CLEAR: begin
            mask_we    = 1'b1;
            mask_waddr = clr_cnt_ff;
            if (clr_cnt_ff == ADDR_W'(VECTOR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_word;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            unique case (req_ff.operation)
               OP_LOAD_X: begin
                  x_we = idx_ok;
               end
               OP_LOAD_Y: begin
                  if (idx_ok) begin
                     mul_start = 1'b1;
                     state_in  = S_LOADY;
                  end
               end
               OP_MARK: begin
                  mask_we   = idx_ok;
                  mask_wbit = 1'b1;
               end
               OP_CLEAR: begin
                  clr_cnt_in = '0;
                  state_in   = S_CLEAR;
               end
               OP_TRIPLET: begin
                  y_raddr = ADDR_W'(dst_idx);
                  if (dst_ok && src_ok) begin
                     x_re      = 1'b1;
                     y_re      = 1'b1;
                     mask_re   = 1'b1;
                     mul_start = 1'b1;
                     state_in  = S_TRI_MUL1;
                  end
               end
               OP_READ: begin
                  y_re     = idx_ok;
                  state_in = S_RESP;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_LOADY: begin
            if (mul_stat.done) begin
               y_we     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_TRI_MUL1: begin
            mul_a = OPA_W'(mul_result);
            mul_b = DATA_W'($signed(x_rd));
            if (mul_stat.done) begin
               // drop the term when the destination is fixed
               if (mask_rd[0]) begin
                  state_in = S_IDLE;
               end else begin
                  mul_start = 1'b1;
                  state_in  = S_TRI_MUL2;
               end
            end
         end
         S_TRI_MUL2: begin
            y_waddr = ADDR_W'(dst_idx);
            y_wdata = sat_add(y_rd, mul_result);
            if (mul_stat.done) begin
               y_we     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (rsp_load) begin
         rsp_in.result_value = idx_ok ? y_rd32 : '0;
         rsp_in.result_index = req_ff.entry_index;
         rsp_in.read_status  = ~idx_ok;
      end
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= GAIN_ONE;
         beta_ff      <= GAIN_ONE;
         transpose_ff <= 1'b0;
         vlen_ff      <= VLEN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ALPHA:     alpha_ff     <= csr_data;
            CSR_BETA:      beta_ff      <= csr_data;
            CSR_TRANSPOSE: transpose_ff <= csr_data[0];
            CSR_LENGTH:    vlen_ff      <= csr_data[VLEN_W-1:0];
         endcase
      end
   end

   coospmv_ram #(
      .WIDTH (X_W),
      .DEPTH (VECTOR_DEPTH)
   ) u_x_ram (
      .clock   (clock),
      .wr_en   (x_we),
      .wr_addr (ADDR_W'(req_ff.entry_index)),
      .wr_data (x_wdata),
      .rd_en   (x_re),
      .rd_addr (ADDR_W'(src_idx)),
      .rd_data (x_rd)
   );

   coospmv_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (VECTOR_DEPTH)
   ) u_y_ram (
      .clock   (clock),
      .wr_en   (y_we),
      .wr_addr (y_waddr),
      .wr_data (y_wdata),
      .rd_en   (y_re),
      .rd_addr (y_raddr),
      .rd_data (y_rd)
   );

   coospmv_ram #(
      .WIDTH (1),
      .DEPTH (VECTOR_DEPTH)
   ) u_mask_ram (
      .clock   (clock),
      .wr_en   (mask_we),
      .wr_addr (mask_waddr),
      .wr_data (mask_wbit),
      .rd_en   (mask_re),
      .rd_addr (ADDR_W'(dst_idx)),
      .rd_data (mask_rd)
   );

   coospmv_qmul #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_qmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .result (mul_result),
      .stat   (mul_stat)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign csr_ready = 1'b1;

   a_idle_mul_free: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !mul_stat.busy)
      else $error("multiplier busy while a new word is taken");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |->
         (state_ff == S_LOADY || state_ff == S_TRI_MUL1 || state_ff == S_TRI_MUL2))
      else $error("multiplier result arrived with no sequencer step waiting");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy)
      else $error("multiplier started while still busy");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_RESP)
      else $error("response raised outside the response step");

endmodule

[src/coospmv_ram.sv]
module coospmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/coospmv_qmul.sv]
module coospmv_qmul
   import coospmv_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   localparam int OPA_W = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [OPA_W-1:0]       op_a,
   input  logic signed [DATA_W-1:0]      op_b,
   output logic signed [VALUE_WIDTH-1:0] result,
   output mul_stat_type                  stat
);

   localparam int LIMBS  = (OPA_W + LIMB_W - 1) / LIMB_W;
   localparam int PAD_W  = LIMBS * LIMB_W;
   localparam int PROD_W = PAD_W + LIMB_W;
   localparam int MAG_W  = PROD_W - FRAC_BITS;
   localparam int CNT_W  = $clog2(LIMBS + 1);

   localparam logic [MAG_W-1:0] LIM_NEG = MAG_W'(1) << (VALUE_WIDTH - 1);
   localparam logic [MAG_W-1:0] LIM_POS = LIM_NEG - MAG_W'(1);

   localparam logic [1:0] Q_IDLE = 2'd0;
   localparam logic [1:0] Q_MUL  = 2'd1;
   localparam logic [1:0] Q_FIN  = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;
   logic [PAD_W-1:0]         ua_ff, ua_in;
   logic [LIMB_W-1:0]        ub_ff, ub_in;
   logic [2*LIMB_W-1:0]      pp_ff, pp_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0]   result_ff, result_in;
   logic                     done_ff, done_in;

   logic [OPA_W-1:0]         a_mag;
   logic [LIMB_W-1:0]        b_mag;
   logic [MAG_W-1:0]         mag;
   logic [MAG_W-1:0]         lim;
   logic [MAG_W-1:0]         sat_mag;
   logic [VALUE_WIDTH-1:0]   res_mag;

   assign a_mag   = op_a[OPA_W-1] ? (~op_a + 1'b1) : op_a;
   assign b_mag   = op_b[DATA_W-1] ? (~op_b + 1'b1) : op_b;
   // drop the fraction by truncating the magnitude, so the result rounds toward zero
   assign mag     = acc_ff[PROD_W-1:FRAC_BITS];
   assign lim     = neg_ff ? LIM_NEG : LIM_POS;
   assign sat_mag = (mag > lim) ? lim : mag;
   assign res_mag = sat_mag[VALUE_WIDTH-1:0];

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      ua_in     = ua_ff;
      ub_in     = ub_ff;
      pp_in     = pp_ff;
      acc_in    = acc_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         Q_IDLE: begin
            if (start) begin
               neg_in   = op_a[OPA_W-1] ^ op_b[DATA_W-1];
               ua_in    = PAD_W'(a_mag);
               ub_in    = b_mag;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = Q_MUL;
            end
         end
         Q_MUL: begin
            // top limb first: shift the running sum up one limb and add the new part
            pp_in  = ua_ff[PAD_W-1 -: LIMB_W] * ub_ff;
            ua_in  = ua_ff << LIMB_W;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               acc_in = (acc_ff << LIMB_W) + PROD_W'(pp_ff);
            end
            if (cnt_ff == CNT_W'(LIMBS)) begin
               state_in = Q_FIN;
            end
         end
         Q_FIN: begin
            result_in = neg_ff ? (~res_mag + 1'b1) : res_mag;
            done_in   = 1'b1;
            state_in  = Q_IDLE;
         end
         default: begin
            state_in = Q_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      ua_ff     <= ua_in;
      ub_ff     <= ub_in;
      pp_ff     <= pp_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign result    = result_ff;
   assign stat.busy = (state_ff != Q_IDLE);
   assign stat.done = done_ff;

endmodule
